// File: design/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DQ_DEPTH  = 16;
	localparam int DQ_DATA_W = 32;

	typedef logic signed [DQ_DATA_W-1:0] dq_data_t;

	typedef enum logic [1:0] {
		DQ_PUT_BACK   = 2'd0,
		DQ_TAKE_BACK  = 2'd1,
		DQ_PUT_FRONT  = 2'd2,
		DQ_TAKE_FRONT = 2'd3
	} dq_func_t;

	typedef enum logic [1:0] {
		DQ_ST_DONE  = 2'd0,
		DQ_ST_EMPTY = 2'd1,
		DQ_ST_FULL  = 2'd2
	} dq_status_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic shift_in;   // push front: take left neighbor
		logic shift_out;  // pop front: take right neighbor
		logic load;       // push back: the selected tail cell takes the word
	} dq_ctrl_t;

endpackage

// File: design/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot of the row; shifts toward either neighbor or loads a word.
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; (
	input  logic     clk,
	input  dq_ctrl_t ctrl,
	input  logic     tail_sel,
	input  dq_data_t left_data,
	input  dq_data_t right_data,
	input  dq_data_t wr_data,
	output dq_data_t data
);

	dq_data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_in) begin
			data_q <= left_data;
		end else if (ctrl.shift_out) begin
			data_q <= right_data;
		end else if (ctrl.load && tail_sel) begin
			data_q <= wr_data;
		end
	end

	assign data = data_q;

endmodule

// File: design/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue keeps up to DEPTH words packed from cell 0 (the front) toward
// higher cells; the back word sits in cell count-1. A push at the front
// shifts the whole row one cell up and drops the word into cell 0, a pop at
// the front shifts the row one cell down, a push at the back writes the cell
// just past the last word, and a pop at the back only lowers the count.
// Every input word gives exactly one result word: status, count after the
// operation, and the front and back words (0 when the queue is empty).
// A pop on an empty queue reports empty and a push on a full queue is
// dropped and reports full; neither changes the contents. For each input
// word the cell row first shifts or loads, and then the front and back
// words are read from the updated row into the output register. The input
// side stalls while a result is waiting to enter the output register, so
// a result held by a stalled output costs the input nothing until the
// next one is ready.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic signed [31:0]   value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     count,
	output logic signed [31:0]   front_value,
	output logic signed [31:0]   back_value
);

	// ---- control state ----
	logic             pend_q;       // operation done, result not yet registered
	logic [CNT_W-1:0] entry_cnt_q;
	dq_status_t       op_status_q;

	// ---- result register ----
	logic             out_valid_q;
	dq_status_t       res_status_q;
	logic [CNT_W-1:0] res_count_q;
	dq_data_t         res_front_q;
	dq_data_t         res_back_q;

	logic             in_acc;
	logic             rpt;
	logic             full;
	logic             empty;
	dq_ctrl_t         ctrl;
	dq_status_t       op_status;
	logic [CNT_W-1:0] cnt_nxt;
	logic [CNT_W-1:0] back_pos;
	logic [IDX_W-1:0] back_idx;
	dq_data_t         cell_data [DEPTH];

	assign in_stall = pend_q;
	assign in_acc   = in_valid && !in_stall;
	// result moves into the output register once that register is free
	assign rpt      = pend_q && (!out_valid_q || !out_stall);

	assign full  = (entry_cnt_q == CNT_W'(DEPTH));
	assign empty = (entry_cnt_q == '0);

	// decode the operation into a row command and the new count
	always_comb begin
		ctrl      = '0;
		op_status = DQ_ST_DONE;
		cnt_nxt   = entry_cnt_q;
		case (dq_func_t'(func))
			DQ_PUT_BACK, DQ_PUT_FRONT: begin
				if (full) begin
					op_status = DQ_ST_FULL;
				end else begin
					ctrl.load     = (dq_func_t'(func) == DQ_PUT_BACK);
					ctrl.shift_in = (dq_func_t'(func) == DQ_PUT_FRONT);
					cnt_nxt       = entry_cnt_q + CNT_W'(1);
				end
			end
			DQ_TAKE_BACK, DQ_TAKE_FRONT: begin
				if (empty) begin
					op_status = DQ_ST_EMPTY;
				end else begin
					ctrl.shift_out = (dq_func_t'(func) == DQ_TAKE_FRONT);
					cnt_nxt        = entry_cnt_q - CNT_W'(1);
				end
			end
			default: begin
				op_status = DQ_ST_DONE;
			end
		endcase
		if (!in_acc) begin
			ctrl = '0;
		end
	end

	// ---- row of cells: cell 0 is the front ----
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dq_data_t left_d;
		dq_data_t right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.tail_sel   (entry_cnt_q == CNT_W'(i)),
			.left_data  (left_d),
			.right_data (right_d),
			.wr_data    (value),
			.data       (cell_data[i])
		);
	end

	// back word lives at cell count-1 (only read when the queue is non-empty)
	assign back_pos = entry_cnt_q - CNT_W'(1);
	assign back_idx = back_pos[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			entry_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				pend_q      <= 1'b1;
				entry_cnt_q <= cnt_nxt;
			end else if (rpt) begin
				pend_q <= 1'b0;
			end
			if (rpt) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_status_q <= op_status;
		end
		if (rpt) begin
			res_status_q <= op_status_q;
			res_count_q  <= entry_cnt_q;
			res_front_q  <= empty ? '0 : cell_data[0];
			res_back_q   <= empty ? '0 : cell_data[back_idx];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_status_q;
	assign count       = res_count_q;
	assign front_value = res_front_q;
	assign back_value  = res_back_q;

	// ---- checks ----
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> pend_q && $stable(entry_cnt_q) == 1'b0 || pend_q)
		else $error("accepted word left no pending result");

	a_res_count: assert property (@(posedge clk) disable iff (!arst_n)
		rpt |=> out_valid_q && res_count_q == entry_cnt_q)
		else $error("registered count differs from queue state");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rpt && empty |=> res_front_q == '0 && res_back_q == '0)
		else $error("empty queue reported nonzero end words");

endmodule
